/* sv/pba_pkg.sv */
// Shared types and constants for the pooled bitmap ID allocator.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  localparam int ACT_W  = 1;
  localparam int POOL_W = 3;
  localparam int ID_W   = 6;
  localparam int CNT_W  = 7;

  // Search the allocation map in groups of eight bits.
  localparam int GRP_SIZE = 8;
  localparam int GRP_W    = 3;
  localparam int GSEL_W   = ID_W - GRP_W;
  localparam int MAX_POOLS = 1 << POOL_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } result_code_t;

  typedef struct packed {
    action_t           action;
    logic [POOL_W-1:0] pool;
    logic [ID_W-1:0]   id;
  } req_t;

  typedef struct packed {
    result_code_t     status;
    logic [ID_W-1:0]  id_res;
    logic [CNT_W-1:0] in_use;
  } rsp_t;

endpackage

`default_nettype wire

/* sv/pba_ffz.sv */
// Find-first-zero search over one allocation map, two levels of eight.
`timescale 1ns / 1ps
`default_nettype none

module pba_ffz
  import pba_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  wire logic [WIDTH-1:0] map,
  output logic                  found,
  output logic [ID_W-1:0]       idx
);

  localparam int NGRP = (WIDTH + GRP_SIZE - 1) / GRP_SIZE;

  logic [NGRP*GRP_SIZE-1:0] padded;
  logic [NGRP-1:0]          grp_zero;
  logic [GRP_W-1:0]         grp_idx [NGRP];

  // Pad bits above the map read as taken.
  always_comb begin
    padded             = '1;
    padded[WIDTH-1:0]  = map;
  end

  // Lowest clear bit inside each group.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_zero[g] = ~&padded[g*GRP_SIZE +: GRP_SIZE];
      grp_idx[g]  = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (!padded[g*GRP_SIZE + b]) begin
          grp_idx[g] = GRP_W'(b);
        end
      end
    end
  end

  // Lowest group that holds a clear bit.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_zero[g]) begin
        found = 1'b1;
        idx   = {GSEL_W'(g), grp_idx[g]};
      end
    end
  end

endmodule

`default_nettype wire

/* sv/pooled_bitmap_id_allocator.sv */
// Top level of the pooled bitmap ID allocator.
// Keeps up to eight independent ID pools, each an allocation map of IDS_PER_POOL bits and a
// count of IDs in use, all cleared by reset. An allocate transaction returns the lowest free
// ID of its pool and marks it taken, or reports the pool full; a free transaction returns an
// ID to its pool, reporting "pool not found" for an empty or absent pool and "not allocated"
// for an ID that is not taken. Exactly one result transaction follows each request, in order.
// Throughput is one transaction per clock while the output is not stalled: the request
// register feeds a single read-modify-write of the addressed pool's map and count, which
// completes in the cycle the result register loads, so the next request already sees the
// updated pool. An accepted request passes through the request register, then the result
// register, which decouples the two channels; a stalled output holds the request stage, and
// the request stage still takes a new transaction whenever its content moves on in the same
// cycle. Pools at or above NUM_POOLS answer "pool not found" with zero fields and never
// change.
`timescale 1ns / 1ps
`default_nettype none

module pooled_bitmap_id_allocator
  import pba_pkg::*;
#(
  parameter int IDS_PER_POOL = 64,
  parameter int NUM_POOLS    = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,

  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);

  // Only pool indexes that fit the request field are ever reachable.
  localparam int POOL_DEPTH = (NUM_POOLS < MAX_POOLS) ? NUM_POOLS : MAX_POOLS;
  localparam int PIDX_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int MIDX_W     = $clog2(IDS_PER_POOL);

  // Request stage and result stage
  logic req_vld_r;
  req_t req_r;
  logic out_vld_r;
  rsp_t rsp_r;
  rsp_t rsp_nxt;

  // Pool state
  logic [IDS_PER_POOL-1:0] map_r [POOL_DEPTH];
  logic [CNT_W-1:0]        cnt_r [POOL_DEPTH];
  logic [IDS_PER_POOL-1:0] map_nxt;
  logic [CNT_W-1:0]        cnt_nxt;
  logic                    wr_en;

  logic                    advance;
  logic                    fire;
  logic                    in_range;
  logic [PIDX_W-1:0]       pidx;
  logic [IDS_PER_POOL-1:0] map_cur;
  logic [CNT_W-1:0]        cnt_cur;
  logic                    id_in_map;
  logic                    id_taken;
  logic                    ffz_found;
  logic [ID_W-1:0]         ffz_idx;

  // Move the request stage on when the result register is free or being drained.
  assign advance  = !out_vld_r || out_ready;
  assign fire     = req_vld_r && advance;
  assign in_ready = !req_vld_r || advance;

  assign out_valid = out_vld_r;
  assign out_data  = rsp_r;

  // Look up the addressed pool; out-of-range pools read as empty.
  assign in_range = ({1'b0, req_r.pool} < (POOL_W + 1)'(POOL_DEPTH));
  assign pidx     = in_range ? req_r.pool[PIDX_W-1:0] : '0;
  assign map_cur  = in_range ? map_r[pidx] : '0;
  assign cnt_cur  = in_range ? cnt_r[pidx] : '0;

  assign id_in_map = ({1'b0, req_r.id} < CNT_W'(IDS_PER_POOL));
  assign id_taken  = id_in_map && map_cur[req_r.id[MIDX_W-1:0]];

  pba_ffz #(
    .WIDTH (IDS_PER_POOL)
  ) u_pba_ffz (
    .map   (map_cur),
    .found (ffz_found),
    .idx   (ffz_idx)
  );

  // Decide the result and the pool update for the held request.
  always_comb begin
    rsp_nxt.status = ST_NOT_FOUND;
    rsp_nxt.id_res = '0;
    rsp_nxt.in_use = '0;
    map_nxt        = map_cur;
    cnt_nxt        = cnt_cur;
    wr_en          = 1'b0;
    if (in_range) begin
      rsp_nxt.in_use = cnt_cur;
      unique case (req_r.action)
        ACT_ALLOC: begin
          if (ffz_found) begin
            map_nxt[ffz_idx[MIDX_W-1:0]] = 1'b1;
            cnt_nxt        = cnt_cur + CNT_W'(1);
            wr_en          = 1'b1;
            rsp_nxt.status = ST_OK;
            rsp_nxt.id_res = ffz_idx;
            rsp_nxt.in_use = cnt_cur + CNT_W'(1);
          end else begin
            rsp_nxt.status = ST_FULL;
          end
        end
        ACT_FREE: begin
          priority if (cnt_cur == '0) begin
            rsp_nxt.status = ST_NOT_FOUND;
            rsp_nxt.in_use = '0;
          end else if (!id_taken) begin
            rsp_nxt.status = ST_NOT_ALLOC;
          end else begin
            map_nxt[req_r.id[MIDX_W-1:0]] = 1'b0;
            cnt_nxt        = cnt_cur - CNT_W'(1);
            wr_en          = 1'b1;
            rsp_nxt.status = ST_OK;
            rsp_nxt.in_use = cnt_cur - CNT_W'(1);
          end
        end
        default: begin
          rsp_nxt.status = ST_NOT_FOUND;
        end
      endcase
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        req_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= req_vld_r;
      end
    end
  end

  // Payload registers: capture on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (fire) begin
      rsp_r <= rsp_nxt;
    end
  end

  // Pool maps and counts: clear on reset, write back once per completed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < POOL_DEPTH; p++) begin
        map_r[p] <= '0;
        cnt_r[p] <= '0;
      end
    end else if (fire && wr_en) begin
      map_r[pidx] <= map_nxt;
      cnt_r[pidx] <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/pba_chk.sv */
// Port-level checks for the pooled bitmap ID allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pba_chk
  import pba_pkg::*;
#(
  parameter int IDS_PER_POOL = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire rsp_t out_data
);

  // Hold a stalled result transaction unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  // Drop any result after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A full pool reports every ID taken and no grant.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      out_data.in_use == CNT_W'(IDS_PER_POOL) && out_data.id_res == '0)
    else $error("pool full with inconsistent fields");

  // A failed request grants nothing; an absent pool reports no IDs.
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NOT_FOUND || out_data.status == ST_NOT_ALLOC) |->
      out_data.id_res == '0 && (out_data.status != ST_NOT_FOUND || out_data.in_use == '0))
    else $error("failed request with non-zero fields");

  // The count never exceeds the pool size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.in_use <= CNT_W'(IDS_PER_POOL))
    else $error("in-use count above pool size");

endmodule

bind pooled_bitmap_id_allocator pba_chk #(
  .IDS_PER_POOL (IDS_PER_POOL)
) u_pba_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
